// ===== sv/mac_table_with_ageing_assert.svh =====
// Assertion macros for the MAC table top level.
// Expects clk and arst_n in scope where the macros are used.
`ifndef MAC_TABLE_WITH_AGEING_ASSERT_SVH
`define MAC_TABLE_WITH_AGEING_ASSERT_SVH

// Same-cycle implication.
`define MTA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mta_pkg.sv =====
// Shared types, constants and functions for the MAC table with ageing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mta_pkg;

	localparam int BUCKETS = 64;
	localparam int WAYS    = 4;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [30:0] MAX_AGE_RST = 31'd360000;

	typedef enum logic [2:0] {
		MODE_INSERT    = 3'd0,
		MODE_LOOKUP    = 3'd1,
		MODE_DELETE    = 3'd2,
		MODE_FLUSH_ALL = 3'd3,
		MODE_FLUSH_EXP = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_LK_RD, S_LK_EX, S_SW_RD, S_SW_CHK, S_FIN
	} state_t;

	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] stamp;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic load_in;
		logic clr_all;
		logic rd_lk;
		logic op_do;
		logic swp_start;
		logic rd_sw;
		logic swp_chk;
		logic swp_inc;
		logic out_load;
	} mta_cmd_t;

	typedef struct packed {
		logic swp_last;
		logic out_free;
	} mta_sts_t;

	function automatic logic [BKT_W-1:0] hash_bucket(input logic [47:0] mac);
		logic [19:0] x;
		x = '0;
		for (int i = 5; i >= 0; i--) begin
			x = {x[17:0], 2'b00} ^ {12'd0, mac[8*i +: 8]};
		end
		x = x ^ (x >> 8);
		return x[BKT_W-1:0];
	endfunction

	function automatic logic aged(input logic [31:0] stamp, input logic [31:0] now,
			input logic [30:0] max_age);
		logic [31:0] limit;
		logic [31:0] diff;
		limit = stamp + {1'b0, max_age};
		diff  = now - limit;
		return !diff[31];
	endfunction

endpackage

`default_nettype wire

// ===== sv/mta_ctrl.sv =====
// Controller FSM for the MAC table: sequences lookups, sweeps and result hand-off.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_ctrl import mta_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [2:0] mode,
	output logic            in_ready,
	input  wire mta_sts_t   sts,
	output mta_cmd_t        cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					unique case (mode)
						MODE_INSERT, MODE_LOOKUP, MODE_DELETE: state_d = S_LK_RD;
						MODE_FLUSH_ALL: begin
							cmd.clr_all = 1'b1;
							state_d     = S_FIN;
						end
						MODE_FLUSH_EXP: begin
							cmd.swp_start = 1'b1;
							state_d       = S_SW_RD;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_LK_RD: begin
				cmd.rd_lk = 1'b1;
				state_d   = S_LK_EX;
			end
			S_LK_EX: begin
				cmd.op_do = 1'b1;
				state_d   = S_FIN;
			end
			S_SW_RD: begin
				cmd.rd_sw = 1'b1;
				state_d   = S_SW_CHK;
			end
			S_SW_CHK: begin
				cmd.swp_chk = 1'b1;
				if (sts.swp_last) begin
					state_d = S_FIN;
				end else begin
					cmd.swp_inc = 1'b1;
					state_d     = S_SW_RD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/mta_dp.sv =====
// Datapath for the MAC table: entry memory, valid bits, way compare, output register.
// Depends on mta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mta_dp import mta_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mta_cmd_t    cmd,
	output mta_sts_t         sts,
	input  wire logic [2:0]  mode,
	input  wire logic [47:0] mac,
	input  wire logic [31:0] now,
	input  wire logic        cfg_we,
	input  wire logic [30:0] cfg_wdata,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             hit,
	output logic             expired,
	output logic [5:0]       bucket
);

	row_t mem [BUCKETS];
	row_t row_s1;

	logic [BUCKETS-1:0][WAYS-1:0] vld_q;
	logic [30:0]      max_age_q;
	logic [2:0]       mode_q;
	logic [47:0]      mac_q;
	logic [31:0]      now_q;
	logic [BKT_W-1:0] bkt_q;
	logic [BKT_W-1:0] swp_q;

	logic [1:0] res_st_q;
	logic       res_hit_q, res_exp_q;
	logic [5:0] res_bkt_q;
	logic       out_valid_q;

	logic [WAYS-1:0]  vrow;
	logic             hit_any, free_any;
	logic [WAY_W-1:0] hit_way, free_way, wr_way;
	logic             mem_we;
	row_t             wr_row;
	logic [BKT_W-1:0] rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_age_q <= MAX_AGE_RST;
		else if (cfg_we) max_age_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			mac_q  <= mac;
			now_q  <= now;
			bkt_q  <= hash_bucket(mac);
		end
	end

	// way search over the bucket row
	always_comb begin
		vrow     = vld_q[bkt_q];
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vrow[w] && row_s1[w].mac == mac_q) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!vrow[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		wr_way = hit_any ? hit_way : free_way;
		mem_we = cmd.op_do && mode_q == MODE_INSERT && (hit_any || free_any);
		wr_row = row_s1;
		wr_row[wr_way].mac   = mac_q;
		wr_row[wr_way].stamp = now_q;
		rd_addr = cmd.rd_lk ? bkt_q : swp_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[bkt_q] <= wr_row;
		if (cmd.rd_lk || cmd.rd_sw) row_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clr_all) begin
			vld_q <= '0;
		end else if (cmd.op_do) begin
			if (mem_we) vld_q[bkt_q][wr_way] <= 1'b1;
			else if (mode_q == MODE_DELETE && hit_any) vld_q[bkt_q][hit_way] <= 1'b0;
		end else if (cmd.swp_chk) begin
			for (int w = 0; w < WAYS; w++) begin
				if (vld_q[swp_q][w] && aged(row_s1[w].stamp, now_q, max_age_q))
					vld_q[swp_q][w] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           swp_q <= '0;
		else if (cmd.swp_start) swp_q <= '0;
		else if (cmd.swp_inc)   swp_q <= swp_q + 1'b1;
	end

	assign sts.swp_last = (swp_q == BKT_W'(BUCKETS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_st_q  <= ST_DONE;
			res_hit_q <= 1'b0;
			res_exp_q <= 1'b0;
			res_bkt_q <= '0;
		end else if (cmd.op_do) begin
			res_bkt_q <= 6'(bkt_q);
			res_hit_q <= hit_any;
			res_exp_q <= 1'b0;
			if (mode_q == MODE_INSERT) begin
				res_st_q <= mem_we ? ST_DONE : ST_FULL;
			end else if (!hit_any) begin
				res_st_q <= ST_NOTFOUND;
			end else begin
				res_st_q <= ST_DONE;
				if (mode_q == MODE_LOOKUP)
					res_exp_q <= aged(row_s1[hit_way].stamp, now_q, max_age_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready)    out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status  <= res_st_q;
			hit     <= res_hit_q;
			expired <= res_exp_q;
			bucket  <= res_bkt_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/mac_table_with_ageing.sv =====
// MAC table with ageing: hashed buckets of WAYS entries, insert/lookup/delete/flush.
// Top level; instantiates mta_ctrl and mta_dp, uses mta_pkg and the assert macros.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one beat: mode, mac, now.
//  - Output channel (out_valid/out_ready) returns one beat per input beat:
//    status, hit, expired, bucket, in input order.
//  - cfg_we/cfg_wdata writes max_age; write only while the block is idle.
//  - Insert, lookup, delete: after accept the block steps through row read,
//    way compare and output load, then out_valid rises.
//  - Flush-all: all valid bits clear at accept, then the result is loaded.
//  - Flush-expired: the sweep reads and then checks one bucket row at a time,
//    over all BUCKETS rows, before the result is loaded.
//  - One item in flight; a new beat is taken once the previous result sits
//    in the output register, even if the receiver has not taken it yet.
//  - Receiver stall: the result holds in the output register; a finished
//    item then waits in its final state until the register frees.
//  - Reset: all valid bits clear at once, max_age returns to 360000, no
//    clearing pass is needed; entry contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "mac_table_with_ageing_assert.svh"

module mac_table_with_ageing import mta_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  mode,
	input  wire logic [47:0] mac,
	input  wire logic [31:0] now,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             hit,
	output logic             expired,
	output logic [5:0]       bucket,
	input  wire logic        cfg_we,
	input  wire logic [30:0] cfg_wdata
);

	mta_cmd_t cmd;
	mta_sts_t sts;

	// sequencing
	mta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, compare, ageing, result register
	mta_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mode      (mode),
		.mac       (mac),
		.now       (now),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.hit       (hit),
		.expired   (expired),
		.bucket    (bucket)
	);

	// one item at a time
	`MTA_ASSERT_NXT(a_one_inflight, in_valid && in_ready, !in_ready, "second beat taken while busy")
	// full bucket never reports a hit
	`MTA_ASSERT_NOW(a_full_nohit, out_valid && status == ST_FULL, !hit && !expired, "full with hit")
	// expired only on a hit that completed
	`MTA_ASSERT_NOW(a_exp_hit, out_valid && expired, hit && status == ST_DONE, "expired without hit")

endmodule

`default_nettype wire

// ===== test/mac_table_checker.sv =====
// Scoreboard for the MAC table: predicts every result from the input and config beats.
// Depends on mta_pkg for mode and status codes and the max_age reset value.
`timescale 1ns / 1ps

module mac_table_checker import mta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [47:0] mac,
	input  logic [31:0] now,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic        hit,
	input  logic        expired,
	input  logic [5:0]  bucket,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	output int          errors,
	output int          pending,
	output int          results
);

	localparam int SLOTS = BUCKETS * WAYS;

	typedef struct {
		logic [1:0] status;
		logic       hit;
		logic       expired;
		logic [5:0] bucket;
	} answer_t;

	answer_t     answers_due[$];
	logic        slot_used[SLOTS];
	logic [47:0] slot_mac[SLOTS];
	logic [31:0] slot_stamp[SLOTS];
	logic [30:0] age_limit;

	function automatic logic [5:0] bucket_of(input logic [47:0] a);
		logic [31:0] x;
		x = '0;
		for (int i = 5; i >= 0; i--)
			x = (x << 2) ^ {24'd0, a[8*i +: 8]};
		x = x ^ (x >> 8);
		return x[5:0];
	endfunction

	function automatic logic is_stale(input logic [31:0] stamp, input logic [31:0] t);
		logic [31:0] d;
		d = t - (stamp + {1'b0, age_limit});
		return !d[31];
	endfunction

	function automatic answer_t apply_op(input logic [2:0] m, input logic [47:0] a,
			input logic [31:0] t);
		answer_t r;
		int b;
		int way;
		r = '{ST_DONE, 1'b0, 1'b0, 6'd0};
		case (m)
			MODE_INSERT, MODE_LOOKUP, MODE_DELETE: begin
				b = int'(bucket_of(a));
				r.bucket = b[5:0];
				way = -1;
				for (int w = 0; w < WAYS; w++)
					if (way < 0 && slot_used[b*WAYS+w] && slot_mac[b*WAYS+w] == a)
						way = w;
				r.hit = (way >= 0);
				if (m == MODE_INSERT) begin
					if (way < 0)
						for (int w = 0; w < WAYS; w++)
							if (way < 0 && !slot_used[b*WAYS+w])
								way = w;
					if (way < 0) begin
						r.status = ST_FULL;
					end else begin
						slot_used[b*WAYS+way]  = 1'b1;
						slot_mac[b*WAYS+way]   = a;
						slot_stamp[b*WAYS+way] = t;
					end
				end else if (way < 0) begin
					r.status = ST_NOTFOUND;
				end else if (m == MODE_LOOKUP) begin
					r.expired = is_stale(slot_stamp[b*WAYS+way], t);
				end else begin
					slot_used[b*WAYS+way] = 1'b0;
				end
			end
			MODE_FLUSH_ALL: begin
				foreach (slot_used[i])
					slot_used[i] = 1'b0;
			end
			MODE_FLUSH_EXP: begin
				foreach (slot_used[i])
					if (slot_used[i] && is_stale(slot_stamp[i], t))
						slot_used[i] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			age_limit = MAX_AGE_RST;
			answers_due.delete();
			errors  = 0;
			pending = 0;
			results = 0;
		end else begin
			// result side first: it belongs to an older beat than any taken now
			if (out_valid && out_ready) begin
				results++;
				if (answers_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with nothing outstanding", $realtime);
				end else begin
					want = answers_due.pop_front();
					if (want.status !== status || want.hit !== hit ||
							want.expired !== expired || want.bucket !== bucket) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: mismatch exp st=%0d hit=%0d exp=%0d bkt=%0d",
								" got st=%0d hit=%0d exp=%0d bkt=%0d"},
								$realtime, want.status, want.hit, want.expired,
								want.bucket, status, hit, expired, bucket);
					end
				end
			end
			if (cfg_we)
				age_limit = cfg_wdata;
			if (in_valid && in_ready)
				answers_due.push_back(apply_op(mode, mac, now));
			pending = answers_due.size();
		end
	end

endmodule

// ===== test/tb_mac_table_with_ageing.sv =====
// Testbench top for mac_table_with_ageing: clock, reset, stimulus and verdict.
// Depends on mta_pkg, the block under test and mac_table_checker.
`timescale 1ns / 1ps

module tb_mac_table_with_ageing;
	import mta_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  mode;
	logic [47:0] mac;
	logic [31:0] now;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        hit;
	logic        expired;
	logic [5:0]  bucket;
	logic        cfg_we;
	logic [30:0] cfg_wdata;

	int errors;
	int pending;
	int results;
	int cycles = 0;
	int beats_sent;
	int age_settings;
	bit no_idle;          // back-to-back stretch: neither side idles
	logic [31:0] tick;    // running time base for well-formed traffic
	logic [47:0] seeds[4];

	localparam int CYCLE_LIMIT = 2000000;

	mac_table_with_ageing uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.mac       (mac),
		.now       (now),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.hit       (hit),
		.expired   (expired),
		.bucket    (bucket),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	mac_table_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.mac       (mac),
		.now       (now),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.hit       (hit),
		.expired   (expired),
		.bucket    (bucket),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.results   (results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: per result, random stall unless no_idle, then hold ready until taken.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// One input beat. Called at a falling edge; returns at the falling edge after accept.
	task automatic send(input logic [2:0] m, input logic [47:0] a, input logic [31:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode     <= m;
		mac      <= a;
		now      <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	// Let the pipeline drain completely; a flush-expired sweep is the longest op.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_age(input logic [30:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		age_settings++;
	endtask

	// Sixteen addresses that all land in one bucket: top bits of the last byte
	// sit above the 6-bit index, and byte 1 bits 6/7 are cancelled by last-byte bits 0/1
	// after the fold.
	function automatic logic [47:0] sibling(input logic [47:0] base, input logic [3:0] k);
		logic [47:0] a;
		a = base;
		a[7:6] = a[7:6] ^ k[1:0];
		if (k[2]) begin
			a[14] = ~a[14];
			a[0]  = ~a[0];
		end
		if (k[3]) begin
			a[15] = ~a[15];
			a[1]  = ~a[1];
		end
		return a;
	endfunction

	// Random 48-bit address.
	function automatic logic [47:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	// Mostly legal traffic on colliding addresses, plus noise and unused codes.
	task automatic random_phase(input int n, input int step);
		int pick;
		logic [47:0] a;
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			a = sibling(seeds[$urandom_range(0, 3)], 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 19) == 0)
				tick = $urandom;                // big jump, exercises wrap
			else
				tick = tick + $urandom_range(0, step);
			if (pick < 36)
				send(MODE_INSERT, a, tick);
			else if (pick < 66)
				send(MODE_LOOKUP, a, tick);
			else if (pick < 80)
				send(MODE_DELETE, a, tick);
			else if (pick < 87)
				send(MODE_FLUSH_EXP, rand_mac(), tick);
			else if (pick < 89)
				send(MODE_FLUSH_ALL, rand_mac(), tick);
			else if (pick < 95)
				send(3'($urandom_range(0, 2)), rand_mac(), $urandom);
			else
				send(3'($urandom_range(5, 7)), rand_mac(), $urandom);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		logic [47:0] b;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_LOOKUP;
		mac        = '0;
		now        = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		beats_sent = 0;
		age_settings = 0;
		no_idle    = 1'b0;
		tick       = 32'd1000;
		foreach (seeds[i])
			seeds[i] = rand_mac();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, reset max_age of 360000.
		b = seeds[0];
		send(MODE_INSERT, 48'h0, 32'h0);
		send(MODE_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_LOOKUP, 48'h0, 32'd359999);           // one tick short of aged
		send(MODE_LOOKUP, 48'h0, 32'd360000);           // aged exactly at the limit
		send(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'd359998); // stamp+age wraps past zero
		send(MODE_LOOKUP, 48'h1234_5678_9ABC, 32'd5);   // miss
		send(MODE_DELETE, 48'hFFFF_FFFF_FFFF, 32'd6);
		send(MODE_DELETE, 48'hFFFF_FFFF_FFFF, 32'd7);   // miss after delete
		for (int k = 0; k < 5; k++)                     // fill a bucket, fifth is full
			send(MODE_INSERT, sibling(b, 4'(k)), 32'(100 + k));
		send(MODE_INSERT, sibling(b, 4'd2), 32'd400000); // overwrite in place
		send(MODE_DELETE, sibling(b, 4'd1), 32'd1);
		send(MODE_INSERT, sibling(b, 4'd4), 32'd2);     // takes the freed lowest way
		send(MODE_FLUSH_EXP, 48'h0, 32'd360101);        // ages out entries stamped 0, 2 and 100 only
		send(MODE_LOOKUP, sibling(b, 4'd2), 32'd400001);
		send(MODE_FLUSH_ALL, 48'hA5A5_A5A5_A5A5, 32'd0);
		send(MODE_LOOKUP, sibling(b, 4'd4), 32'd3);
		send(3'd5, 48'h0, 32'd0);
		send(3'd6, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send(3'd7, 48'h5A5A_5A5A_5A5A, 32'h8000_0000);

		// Hold off until the table is quiet before moving on.
		drain();
		random_phase(240, 200000);
		set_age(31'd1);
		random_phase(240, 3);
		set_age(31'h7FFF_FFFF);
		random_phase(240, 50000);
		set_age(31'd50);
		random_phase(240, 30);
		set_age(31'd1000);
		random_phase(240, 600);
		set_age(31'($urandom_range(1, 32'h7FFF_FFFF)));
		random_phase(230, 32'h0100_0000);

		drain();
		repeat (140) @(negedge clk);
		$display("Sent %0d beats, checked %0d results under %0d max_age settings.",
			beats_sent, results, age_settings + 1);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
